// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the boot command parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define SBCP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Same, on the block's own clock and reset.
`define SBCP_ASSERT_DEF(lbl, prop, msg) `SBCP_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: design/sbcp_pkg.sv
// ----------------------------------------------------------------------------
// sbcp_pkg
// Types, codes and reset values shared by the boot command parser modules.
// ----------------------------------------------------------------------------
package sbcp_pkg;

  localparam int unsigned PageBytesDef = 64;

  // Fixed command codes for the address display commands
  localparam logic [7:0] CodeShowHigh = 8'd6;
  localparam logic [7:0] CodeShowLow  = 8'd7;

  localparam logic [7:0] NibMask = 8'h0F;

  // Configuration register indexes
  localparam logic [2:0] CfgInitNode = 3'd0;
  localparam logic [2:0] CfgSync     = 3'd1;
  localparam logic [2:0] CfgNop      = 3'd2;
  localparam logic [2:0] CfgBoot     = 3'd3;
  localparam logic [2:0] CfgSetAddr  = 3'd4;
  localparam logic [2:0] CfgBaud     = 3'd5;
  localparam logic [2:0] CfgProgram  = 3'd6;
  localparam logic [2:0] CfgFinish   = 3'd7;

  // Register reset values
  localparam logic [7:0] RstInitNode = 8'd0;
  localparam logic [7:0] RstSync     = 8'd170;
  localparam logic [7:0] RstNop      = 8'd0;
  localparam logic [7:0] RstBoot     = 8'd1;
  localparam logic [7:0] RstSetAddr  = 8'd2;
  localparam logic [7:0] RstBaud     = 8'd3;
  localparam logic [7:0] RstProgram  = 8'd4;
  localparam logic [7:0] RstFinish   = 8'd5;

  typedef enum logic [2:0] {
    EV_PAGE   = 3'd0,
    EV_BOOT   = 3'd1,
    EV_HIGH   = 3'd2,
    EV_LOW    = 3'd3,
    EV_ADDR   = 3'd4,
    EV_FINISH = 3'd5,
    EV_ERASE  = 3'd6
  } ev_e;

  // Controller -> datapath
  typedef struct packed {
    logic addr_hi;     // latch page address high byte, clear count and sum
    logic addr_lo;     // latch page address low byte
    logic store;       // write data byte to page buffer
    logic set_node;    // load node address from received byte
    logic emit_start;  // rewind page index for readout
    logic emit_run;    // page readout in progress
    logic single;      // load a single-result event into the output register
    ev_e  ev;          // event of that single result
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_nop;
    logic is_sync;
    logic is_boot;
    logic is_high;
    logic is_low;
    logic is_set;
    logic is_baud;
    logic is_prog;
    logic is_fin;
    logic page_full;   // this data byte completes the page
    logic csum_ok;     // received byte matches inverted sum
    logic emit_done;   // page readout fully handed to the output register
    logic out_free;    // output register can take a result this cycle
  } dp_sts_t;

endpackage

// File: design/sbcp_ctrl.sv
// ----------------------------------------------------------------------------
// sbcp_ctrl
// Command parser state machine; drives the datapath via a command struct.
// ----------------------------------------------------------------------------
module sbcp_ctrl import sbcp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SYNC    = 4'd1;
  localparam logic [3:0] S_ADDR    = 4'd2;
  localparam logic [3:0] S_BAUD_H  = 4'd3;
  localparam logic [3:0] S_BAUD_L  = 4'd4;
  localparam logic [3:0] S_BAUD_D  = 4'd5;
  localparam logic [3:0] S_PROG_AH = 4'd6;
  localparam logic [3:0] S_PROG_AL = 4'd7;
  localparam logic [3:0] S_PROG_D  = 4'd8;
  localparam logic [3:0] S_PROG_V  = 4'd9;
  localparam logic [3:0] S_EMIT    = 4'd10;
  localparam logic [3:0] S_HALT    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       accept;

  // byte-consuming states are the low codes; halt takes and drops every byte
  assign in_ready_o = ((state_q <= S_PROG_V) && sts_i.out_free) || (state_q == S_HALT);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.ev        = EV_PAGE;
    cmd_o.emit_run  = (state_q == S_EMIT);
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = sts_i.is_sync ? S_SYNC : S_IDLE;
      end
      S_SYNC: begin
        if (accept) begin
          state_d = S_IDLE;
          // priority order of the command decode
          if (sts_i.is_nop) begin
            state_d = S_IDLE;
          end else if (sts_i.is_sync) begin
            state_d = S_SYNC;
          end else if (sts_i.is_boot) begin
            cmd_o.single = 1'b1;
            cmd_o.ev     = EV_BOOT;
          end else if (sts_i.is_high) begin
            cmd_o.single = 1'b1;
            cmd_o.ev     = EV_HIGH;
          end else if (sts_i.is_low) begin
            cmd_o.single = 1'b1;
            cmd_o.ev     = EV_LOW;
          end else if (sts_i.is_set) begin
            state_d = S_ADDR;
          end else if (sts_i.is_baud) begin
            state_d = S_BAUD_H;
          end else if (sts_i.is_prog) begin
            state_d = S_PROG_AH;
          end else if (sts_i.is_fin) begin
            cmd_o.single = 1'b1;
            cmd_o.ev     = EV_FINISH;
          end
        end
      end
      S_ADDR: begin
        if (accept) begin
          cmd_o.set_node = 1'b1;
          cmd_o.single   = 1'b1;
          cmd_o.ev       = EV_ADDR;
          state_d        = S_IDLE;
        end
      end
      S_BAUD_H: begin
        if (accept) state_d = S_BAUD_L;
      end
      S_BAUD_L: begin
        if (accept) state_d = S_BAUD_D;
      end
      S_BAUD_D: begin
        if (accept) state_d = S_IDLE;
      end
      S_PROG_AH: begin
        if (accept) begin
          cmd_o.addr_hi = 1'b1;
          state_d       = S_PROG_AL;
        end
      end
      S_PROG_AL: begin
        if (accept) begin
          cmd_o.addr_lo = 1'b1;
          state_d       = S_PROG_D;
        end
      end
      S_PROG_D: begin
        if (accept) begin
          cmd_o.store = 1'b1;
          if (sts_i.page_full) state_d = S_PROG_V;
        end
      end
      S_PROG_V: begin
        if (accept) begin
          if (sts_i.csum_ok) begin
            cmd_o.emit_start = 1'b1;
            state_d          = S_EMIT;
          end else begin
            cmd_o.single = 1'b1;
            cmd_o.ev     = EV_ERASE;
            state_d      = S_HALT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.emit_done) state_d = S_IDLE;
      end
      S_HALT: begin
        state_d = S_HALT;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/sbcp_dp.sv
// ----------------------------------------------------------------------------
// sbcp_dp
// Code registers, node address, page buffer, checksum and output register.
// ----------------------------------------------------------------------------
module sbcp_dp import sbcp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic [7:0]  rx_byte_i,
  input  dp_cmd_t     cmd_i,
  output dp_sts_t     sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  out_event_o,
  output logic [7:0]  out_value_o,
  output logic [15:0] out_pg_base_o,
  output logic [5:0]  out_offset_o,
  output logic        out_last_o
);

  localparam int unsigned IdxW = $clog2(PAGE_BYTES);
  localparam int unsigned CntW = $clog2(PAGE_BYTES + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(PAGE_BYTES - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(PAGE_BYTES);

  logic [7:0] code_sync_q, code_nop_q, code_boot_q, code_set_q;
  logic [7:0] code_baud_q, code_prog_q, code_fin_q;
  logic [7:0] node_q;

  logic [15:0]     pg_base_q;
  logic [CntW-1:0] fill_q;
  logic [7:0]      sum_q;

  logic [7:0]      mem [PAGE_BYTES];
  logic [7:0]      rd_data_q;
  logic            rd_pend_q;
  logic [IdxW-1:0] rd_ofs_q;
  logic            rd_last_q;

  logic            out_valid_q;
  ev_e             ev_q;
  logic [7:0]      val_q;
  logic [15:0]     pa_q;
  logic [5:0]      ofs_q;
  logic            last_q;

  logic       out_load;
  logic       issue;
  logic [7:0] single_val;

  assign out_load = !out_valid_q || out_ready_i;
  assign issue    = cmd_i.emit_run && (fill_q != CntFull) && (!rd_pend_q || out_load);

  always_comb begin
    sts_o           = '0;
    sts_o.is_nop    = (rx_byte_i == code_nop_q);
    sts_o.is_sync   = (rx_byte_i == code_sync_q);
    sts_o.is_boot   = (rx_byte_i == code_boot_q);
    sts_o.is_high   = (rx_byte_i == CodeShowHigh);
    sts_o.is_low    = (rx_byte_i == CodeShowLow);
    sts_o.is_set    = (rx_byte_i == code_set_q);
    sts_o.is_baud   = (rx_byte_i == code_baud_q);
    sts_o.is_prog   = (rx_byte_i == code_prog_q);
    sts_o.is_fin    = (rx_byte_i == code_fin_q);
    sts_o.page_full = (fill_q == CntLast);
    sts_o.csum_ok   = (~sum_q == rx_byte_i);
    sts_o.emit_done = (fill_q == CntFull) && !rd_pend_q;
    sts_o.out_free  = out_load;
  end

  always_comb begin
    case (cmd_i.ev)
      EV_HIGH: single_val = {4'h0, node_q[7:4]};
      EV_LOW:  single_val = node_q & NibMask;
      EV_ADDR: single_val = rx_byte_i;
      default: single_val = 8'h00;
    endcase
  end

  // configuration and node address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_sync_q <= RstSync;
      code_nop_q  <= RstNop;
      code_boot_q <= RstBoot;
      code_set_q  <= RstSetAddr;
      code_baud_q <= RstBaud;
      code_prog_q <= RstProgram;
      code_fin_q  <= RstFinish;
      node_q      <= RstInitNode;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CfgInitNode: node_q      <= cfg_wdata_i;
          CfgSync:     code_sync_q <= cfg_wdata_i;
          CfgNop:      code_nop_q  <= cfg_wdata_i;
          CfgBoot:     code_boot_q <= cfg_wdata_i;
          CfgSetAddr:  code_set_q  <= cfg_wdata_i;
          CfgBaud:     code_baud_q <= cfg_wdata_i;
          CfgProgram:  code_prog_q <= cfg_wdata_i;
          CfgFinish:   code_fin_q  <= cfg_wdata_i;
          default:     ;
        endcase
      end else if (cmd_i.set_node) begin
        node_q <= rx_byte_i;
      end
    end
  end

  // page address, fill/readout index, running checksum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_base_q <= '0;
      fill_q    <= '0;
      sum_q     <= '0;
    end else begin
      if (cmd_i.addr_hi) begin
        pg_base_q <= {rx_byte_i, 8'h00};
        fill_q    <= '0;
        sum_q     <= '0;
      end else if (cmd_i.addr_lo) begin
        pg_base_q[7:0] <= rx_byte_i;
      end else if (cmd_i.store) begin
        fill_q <= fill_q + CntW'(1);
        sum_q  <= sum_q + rx_byte_i;
      end else if (cmd_i.emit_start) begin
        fill_q <= '0;
      end else if (issue) begin
        fill_q <= fill_q + CntW'(1);
      end
    end
  end

  // page buffer, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[fill_q[IdxW-1:0]] <= rx_byte_i;
    end
    if (issue) begin
      rd_data_q <= mem[fill_q[IdxW-1:0]];
      rd_ofs_q  <= fill_q[IdxW-1:0];
      rd_last_q <= (fill_q == CntLast);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        rd_pend_q <= 1'b1;
      end else if (out_load) begin
        rd_pend_q <= 1'b0;
      end
      if (cmd_i.single || (rd_pend_q && out_load)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.single) begin
      ev_q   <= cmd_i.ev;
      val_q  <= single_val;
      pa_q   <= '0;
      ofs_q  <= '0;
      last_q <= 1'b1;
    end else if (rd_pend_q && out_load) begin
      ev_q   <= EV_PAGE;
      val_q  <= rd_data_q;
      pa_q   <= pg_base_q;
      ofs_q  <= 6'(rd_ofs_q);
      last_q <= rd_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_event_o   = ev_q;
  assign out_value_o   = val_q;
  assign out_pg_base_o = pa_q;
  assign out_offset_o  = ofs_q;
  assign out_last_o    = last_q;

endmodule

// File: design/serial_boot_command_parser.sv
// ----------------------------------------------------------------------------
// serial_boot_command_parser
// Bootloader command stream parser with page buffer and checksum check.
// ----------------------------------------------------------------------------
// Received bytes enter on the slave stream one per transaction. A sync byte
// arms the parser; the following byte picks boot, show high or low nibble of
// the node address, set node address (one operand byte), baud (three operand
// bytes, dropped), finish, or program. Program takes the page address high
// byte, low byte, PAGE_BYTES data bytes and a checksum byte equal to the
// inverted 8-bit sum of the data. On a match the page is read back from the
// internal buffer and sent as PAGE_BYTES page-byte transactions carrying
// address and offset, tlast on the final one. On a mismatch one erase event
// goes out and from then on every byte is taken and dropped until reset.
// Every other byte brings at most one result and is accepted whenever the
// output register is empty or drains in the same cycle. After a matching
// checksum byte is taken the input stays stalled while the page is read
// back through the single read port of the page buffer, one byte a cycle
// while the output register is free; output stalls lengthen the stall.
// Configuration writes are taken in any cycle but are meant for idle time;
// writing the initial node address also loads the live node address.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module serial_boot_command_parser import sbcp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // result events
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [7:0] value, [23:8] page_address,
                                        // [29:24] byte_offset, [31:30] zero
  output logic [2:0]  m_axis_tuser_o,   // [2:0] event_res
  output logic        m_axis_tlast_o
);

  localparam logic [5:0] LastOfs = 6'(PAGE_BYTES - 1);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [7:0]  value;
  logic [15:0] pg_base;
  logic [5:0]  offset;
  logic        out_hs;
  logic        is_erase;
  logic        is_page;

  // parser state machine
  sbcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // code registers, page buffer, checksum, output register
  sbcp_dp #(
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .rx_byte_i     (s_axis_tdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_event_o   (m_axis_tuser_o),
    .out_value_o   (value),
    .out_pg_base_o (pg_base),
    .out_offset_o  (offset),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, offset, pg_base, value};

  assign out_hs   = m_axis_tvalid_o && m_axis_tready_i;
  assign is_erase = (m_axis_tuser_o == EV_ERASE);
  assign is_page  = (m_axis_tuser_o == EV_PAGE);

  // once the erase event has gone out, the block stays silent
  `SBCP_ASSERT_DEF(a_silent_after_erase, (out_hs && is_erase) |=> !m_axis_tvalid_o, "event after erase")
  // the closing page byte sits at the top offset of the page
  `SBCP_ASSERT_DEF(a_page_last_offset, (m_axis_tvalid_o && is_page && m_axis_tlast_o) |-> (offset == LastOfs), "last page byte at wrong offset")
  // erase is a lone result with an empty payload
  `SBCP_ASSERT_DEF(a_erase_payload, (m_axis_tvalid_o && is_erase) |-> (m_axis_tlast_o && (m_axis_tdata_o == '0)), "bad erase payload")

endmodule

// File: test/sbcp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcp_checker
// Watches the byte and event streams of the boot command parser, keeps its
// own copy of parser state and codes, and compares every event transaction.
// ----------------------------------------------------------------------------
module sbcp_checker import sbcp_pkg::*; #(
  parameter int unsigned PAGE_BYTES = PageBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [31:0] m_axis_tdata_i,   // [7:0] value, [23:8] page_address,
                                        // [29:24] byte_offset, [31:30] zero
  input  logic [2:0]  m_axis_tuser_i,   // [2:0] event_res
  input  logic        m_axis_tlast_i,
  output int          pending_o,
  output int          fail_count_o
);

  typedef enum logic [3:0] {
    PS_IDLE, PS_ARMED, PS_NODE, PS_BAUD_H, PS_BAUD_L, PS_BAUD_D,
    PS_ADDR_H, PS_ADDR_L, PS_DATA, PS_CHECK
  } parse_e;

  typedef struct packed {
    ev_e         ev;
    logic [7:0]  value;
    logic [15:0] page;
    logic [5:0]  offset;
    logic        last;
  } boot_event_t;

  boot_event_t events_due[$];
  int          fails = 0;

  logic [7:0]  codes [8];
  parse_e      parse;
  logic [7:0]  page_img [PAGE_BYTES];
  int          fill;
  logic [15:0] tgt_page;
  logic [7:0]  node;
  logic        halted;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] event mismatch, %s: got %0h, want %0h", $time, what, got, want);
    fails++;
  endtask

  task automatic add_event(input ev_e ev, input logic [7:0] value,
                           input logic [15:0] page, input logic [5:0] offset,
                           input logic last);
    boot_event_t e;
    e.ev     = ev;
    e.value  = value;
    e.page   = page;
    e.offset = offset;
    e.last   = last;
    events_due.push_back(e);
  endtask

  task automatic reset_state();
    codes[CfgInitNode] = RstInitNode;
    codes[CfgSync]     = RstSync;
    codes[CfgNop]      = RstNop;
    codes[CfgBoot]     = RstBoot;
    codes[CfgSetAddr]  = RstSetAddr;
    codes[CfgBaud]     = RstBaud;
    codes[CfgProgram]  = RstProgram;
    codes[CfgFinish]   = RstFinish;
    parse    = PS_IDLE;
    fill     = 0;
    tgt_page = '0;
    node     = RstInitNode;
    halted   = 1'b0;
    events_due.delete();
  endtask

  // One received byte through the command state machine.
  task automatic take_rx_byte(input logic [7:0] b);
    logic [7:0] sum;
    logic [7:0] want_sum;
    if (halted) return;
    case (parse)
      PS_IDLE: parse = (b == codes[CfgSync]) ? PS_ARMED : PS_IDLE;
      PS_ARMED: begin
        parse = PS_IDLE;
        // nop outranks sync, sync outranks the rest
        if (b == codes[CfgNop]) begin
        end else if (b == codes[CfgSync]) begin
          parse = PS_ARMED;
        end else if (b == codes[CfgBoot]) begin
          add_event(EV_BOOT, '0, '0, '0, 1'b1);
        end else if (b == CodeShowHigh) begin
          add_event(EV_HIGH, node >> 4, '0, '0, 1'b1);
        end else if (b == CodeShowLow) begin
          add_event(EV_LOW, node & NibMask, '0, '0, 1'b1);
        end else if (b == codes[CfgSetAddr]) begin
          parse = PS_NODE;
        end else if (b == codes[CfgBaud]) begin
          parse = PS_BAUD_H;
        end else if (b == codes[CfgProgram]) begin
          parse = PS_ADDR_H;
        end else if (b == codes[CfgFinish]) begin
          add_event(EV_FINISH, '0, '0, '0, 1'b1);
        end
      end
      PS_NODE: begin
        node  = b;
        parse = PS_IDLE;
        add_event(EV_ADDR, b, '0, '0, 1'b1);
      end
      PS_BAUD_H: parse = PS_BAUD_L;
      PS_BAUD_L: parse = PS_BAUD_D;
      PS_BAUD_D: parse = PS_IDLE;
      PS_ADDR_H: begin
        tgt_page = {b, 8'h00};
        fill     = 0;
        parse    = PS_ADDR_L;
      end
      PS_ADDR_L: begin
        tgt_page[7:0] = b;
        parse         = PS_DATA;
      end
      PS_DATA: begin
        page_img[fill] = b;
        fill++;
        if (fill >= PAGE_BYTES) parse = PS_CHECK;
      end
      PS_CHECK: begin
        parse = PS_IDLE;
        sum   = '0;
        for (int i = 0; i < PAGE_BYTES; i++) sum += page_img[i];
        want_sum = ~sum;
        if (want_sum != b) begin
          halted = 1'b1;
          add_event(EV_ERASE, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < PAGE_BYTES; i++) begin
            add_event(EV_PAGE, page_img[i], tgt_page, i[5:0], i == PAGE_BYTES - 1);
          end
        end
      end
      default: parse = PS_IDLE;
    endcase
  endtask

  task automatic check_event();
    boot_event_t e;
    if (events_due.size() == 0) begin
      report_mismatch("event with none pending", {m_axis_tuser_i, m_axis_tdata_i[28:0]}, '0);
      return;
    end
    e = events_due.pop_front();
    if (m_axis_tuser_i !== e.ev)          report_mismatch("event_res", m_axis_tuser_i, e.ev);
    if (m_axis_tdata_i[7:0] !== e.value)  report_mismatch("value", m_axis_tdata_i[7:0], e.value);
    if (m_axis_tdata_i[23:8] !== e.page)  report_mismatch("page_address", m_axis_tdata_i[23:8],
                                                          e.page);
    if (m_axis_tdata_i[29:24] !== e.offset)
      report_mismatch("byte_offset", m_axis_tdata_i[29:24], e.offset);
    if (m_axis_tdata_i[31:30] !== 2'b00)  report_mismatch("pad bits", m_axis_tdata_i[31:30], '0);
    if (m_axis_tlast_i !== e.last)        report_mismatch("tlast", m_axis_tlast_i, e.last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_state();
      pending_o    <= 0;
      fail_count_o <= fails;
    end else begin
      // an event leaving now cannot stem from a byte taken at this edge
      if (m_axis_tvalid_i && m_axis_tready_i) check_event();
      if (cfg_we_i) begin
        codes[cfg_addr_i] = cfg_wdata_i;
        if (cfg_addr_i == CfgInitNode) node = cfg_wdata_i;
      end
      if (s_axis_tvalid_i && s_axis_tready_i) take_rx_byte(s_axis_tdata_i);
      pending_o    <= events_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the boot command parser: command sequences under
// several code settings, page programs with good checksums, and one bad
// checksum at the very end followed by bytes the halted block drops; all
// events are checked by sbcp_checker.
// ----------------------------------------------------------------------------
module tb;
  import sbcp_pkg::*;

  localparam int PageLen     = PageBytesDef;
  localparam int CyclesMax   = 1_000_000;
  // a good checksum keeps the block busy while it reads back the page
  localparam int DrainCycles = PageLen + 16;

  // page fill patterns
  localparam int FillZeros = 0;
  localparam int FillOnes  = 1;
  localparam int FillRamp  = 2;

  typedef enum {
    K_NOP, K_SYNC, K_BOOT, K_HIGH, K_LOW, K_SET, K_BAUD, K_PROG, K_FIN, K_UNKNOWN
  } cmd_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;

  int          pending;
  int          fail_count;
  int          cycle_count = 0;
  int          ready_hold = 0;

  // stimulus side view of the codes and of the parser being armed by a sync
  logic [7:0]  cfg_val [8];
  bit          armed = 1'b0;
  bit          burst = 1'b0;   // no input gaps while set
  int          bytes_sent = 0;

  always #6ns clk_i = ~clk_i;

  serial_boot_command_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  sbcp_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .m_axis_tlast_i  (m_last),
    .pending_o       (pending),
    .fail_count_o    (fail_count)
  );

  // Watchdog: a hang anywhere ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CyclesMax) begin
      $display("timeout after %0d cycles, %0d events pending", cycle_count, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Event sink backpressure: long ready stretches, short stalls, now and then
  // a long stall.
  always @(posedge clk_i) begin : sink_pace
    int r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        m_ready    <= 1'b1;
        ready_hold <= $urandom_range(1, 40);
      end else if (r < 92) begin
        m_ready    <= 1'b0;
        ready_hold <= $urandom_range(1, 3);
      end else begin
        m_ready    <= 1'b0;
        ready_hold <= $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // How the parser reads a byte right after a sync, same priority as the RTL.
  function automatic cmd_e classify(input logic [7:0] b);
    if (b == cfg_val[CfgNop])     return K_NOP;
    if (b == cfg_val[CfgSync])    return K_SYNC;
    if (b == cfg_val[CfgBoot])    return K_BOOT;
    if (b == CodeShowHigh)        return K_HIGH;
    if (b == CodeShowLow)         return K_LOW;
    if (b == cfg_val[CfgSetAddr]) return K_SET;
    if (b == cfg_val[CfgBaud])    return K_BAUD;
    if (b == cfg_val[CfgProgram]) return K_PROG;
    if (b == cfg_val[CfgFinish])  return K_FIN;
    return K_UNKNOWN;
  endfunction

  function automatic logic [15:0] pick_page();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // One transaction on the byte stream, then an optional idle gap. tvalid
  // stays high into the next byte when there is no gap.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    s_valid <= 1'b1;
    s_data  <= b;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Write all eight registers from cfg_val, one per cycle.
  task automatic write_all_regs();
    for (int i = CfgInitNode; i <= CfgFinish; i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= i[2:0];
      cfg_wdata <= cfg_val[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] init_node, input logic [7:0] sync,
                           input logic [7:0] nop, input logic [7:0] boot,
                           input logic [7:0] set_addr, input logic [7:0] baud,
                           input logic [7:0] prog, input logic [7:0] fin);
    cfg_val[CfgInitNode] = init_node;
    cfg_val[CfgSync]     = sync;
    cfg_val[CfgNop]      = nop;
    cfg_val[CfgBoot]     = boot;
    cfg_val[CfgSetAddr]  = set_addr;
    cfg_val[CfgBaud]     = baud;
    cfg_val[CfgProgram]  = prog;
    cfg_val[CfgFinish]   = fin;
    write_all_regs();
  endtask

  // Address high, address low, a page of data, then the checksum. A corrupt
  // checksum is off by a nonzero xor so it can never match by chance.
  task automatic send_page(input logic [15:0] pg, input int fill_mode, input bit corrupt);
    logic [7:0] data;
    logic [7:0] sum;
    sum = '0;
    send_byte(pg[15:8]);
    send_byte(pg[7:0]);
    for (int i = 0; i < PageLen; i++) begin
      case (fill_mode)
        FillZeros: data = 8'h00;
        FillOnes:  data = 8'hFF;
        FillRamp:  data = i[7:0];
        default:   data = 8'($urandom);
      endcase
      sum += data;
      send_byte(data);
    end
    sum = ~sum;
    if (corrupt) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  task automatic arm();
    if (!armed) begin
      send_byte(cfg_val[CfgSync]);
      armed = 1'b1;
    end
  endtask

  // Command byte on an armed parser, followed by whatever operands the
  // parser will actually expect for it. Checksums are always good here.
  task automatic send_command(input logic [7:0] b, input logic [7:0] operand);
    send_byte(b);
    armed = 1'b0;
    case (classify(b))
      K_SYNC: armed = 1'b1;
      K_SET:  send_byte(operand);
      K_BAUD: repeat (3) send_byte(8'($urandom));
      K_PROG: send_page(pick_page(), $urandom_range(0, 9), 1'b0);
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_command();
    case ($urandom_range(0, 19))
      0, 1:   return cfg_val[CfgNop];
      2:      return cfg_val[CfgSync];
      3, 4:   return cfg_val[CfgBoot];
      5, 6:   return CodeShowHigh;
      7, 8:   return CodeShowLow;
      9, 10:  return cfg_val[CfgSetAddr];
      11, 12: return cfg_val[CfgBaud];
      13, 14,
      15:     return cfg_val[CfgProgram];
      16, 17: return cfg_val[CfgFinish];
      default: return 8'($urandom);
    endcase
  endfunction

  // Stray bytes on an idle parser; a byte equal to sync arms it and ends
  // the noise, so a following noise byte is never taken as a command.
  task automatic send_noise();
    int n;
    logic [7:0] b;
    n = $urandom_range(1, 3);
    while (n > 0 && !armed) begin
      b = 8'($urandom);
      send_byte(b);
      if (b == cfg_val[CfgSync]) armed = 1'b1;
      n--;
    end
  endtask

  // Stop sending until every predicted event has left the block.
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Bring the parser back to idle and let it go quiet before a code change.
  task automatic quiesce();
    while (armed) send_command(8'($urandom), 8'($urandom));
    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_traffic(input int budget);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      burst = ($urandom_range(0, 5) == 0);
      if (!armed && $urandom_range(0, 4) == 0) begin
        send_noise();
      end else begin
        arm();
        send_command(pick_command(), 8'($urandom));
      end
      if ($urandom_range(0, 30) == 0) hold_until_drained();
    end
    burst = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Default codes, known node address for the nibble displays.
    set_codes(8'hA5, RstSync, RstNop, RstBoot, RstSetAddr, RstBaud, RstProgram, RstFinish);

    // Directed: every command but program, node address extremes, sync after sync,
    // nop after sync, an unknown command byte.
    arm(); send_command(CodeShowHigh, '0);
    arm(); send_command(CodeShowLow, '0);
    arm(); send_command(cfg_val[CfgBoot], '0);
    arm(); send_command(cfg_val[CfgSetAddr], 8'hFF);
    arm(); send_command(CodeShowHigh, '0);
    arm(); send_command(CodeShowLow, '0);
    arm(); send_command(cfg_val[CfgSetAddr], 8'h00);
    arm(); send_command(cfg_val[CfgBaud], '0);
    arm(); send_command(cfg_val[CfgFinish], '0);
    arm(); send_command(cfg_val[CfgNop], '0);
    arm(); send_command(cfg_val[CfgSync], '0);
    send_command(cfg_val[CfgBoot], '0);
    arm(); send_command(8'h99, '0);

    // Page extremes: top address with all ones, bottom address with zeros.
    arm(); send_byte(cfg_val[CfgProgram]); armed = 1'b0;
    send_page(16'hFFFF, FillOnes, 1'b0);
    arm(); send_byte(cfg_val[CfgProgram]); armed = 1'b0;
    send_page(16'h0000, FillZeros, 1'b0);
    hold_until_drained();

    random_traffic(20);
    quiesce();

    // Register extremes; new init node must show up in the nibble events.
    set_codes(8'hFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55);
    random_traffic(20);
    quiesce();

    // Colliding codes: nop equals sync, boot shadows show-high, show-low
    // shadows set-address, baud shadows program.
    set_codes(8'h00, 8'h5A, 8'h5A, CodeShowHigh, CodeShowLow, 8'h10, 8'h10, 8'h01);
    random_traffic(20);
    quiesce();

    set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(20);
    quiesce();

    set_codes(8'h5A, 8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 8'hFB, 8'hFA);
    random_traffic(20);
    quiesce();

    // Bad checksum last: the block halts and drops every later byte.
    arm(); send_byte(cfg_val[CfgProgram]); armed = 1'b0;
    send_page(pick_page(), $urandom_range(0, 9), 1'b1);
    repeat (4) send_byte(8'($urandom));
    s_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
